// ----- design/ravss_pkg.sv -----
package ravss_pkg;

   localparam int MaxElemsDefault = 4096;
   localparam int BlockLenDefault = 64;
   localparam int PosWidth        = 13;
   localparam int AmountWidth     = 32;
   localparam int ValueWidth      = 63;
   localparam int WordWidth       = 64;
   localparam int DistWidth       = 12;
   localparam int ModeWidth       = 2;
   localparam logic [PosWidth-1:0] CountReset = 13'd4096;

   typedef enum logic [ModeWidth-1:0] {
      MODE_LOAD  = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_RD,
      ST_Q_CMP,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request, set up cursor
      logic load_wr;    // write loaded element
      logic mem_rd;     // issue read at cursor
      logic add_step;   // apply add at cursor (whole block or element)
      logic q_cmp;      // compare read data, advance cursor
      logic resp_set;   // raise result valid
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       load_ok;
      logic       span_done;   // cursor beyond span end
      logic       whole_blk;   // cursor at start of a fully covered block
      logic       rsp_busy;    // result still waiting
      mode_type   mode;
   } sts_type;

endpackage

// ----- design/ravss_ctrl.sv -----
module ravss_ctrl
   import ravss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  sts_type  sts,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RESP;
               case (sts.mode)
                  MODE_LOAD:  state_in = ST_LOAD;
                  MODE_ADD:   state_in = ST_ADD_RD;
                  MODE_QUERY: state_in = ST_Q_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:   state_in = ST_IDLE;
         ST_ADD_RD: begin
            if (sts.span_done) begin
               state_in = ST_IDLE;
            end else if (!sts.whole_blk) begin
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR: state_in = ST_ADD_RD;
         ST_Q_RD: begin
            if (sts.span_done) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_Q_CMP;
            end
         end
         ST_Q_CMP:  state_in = ST_Q_RD;
         ST_RESP: begin
            if (!sts.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_LOAD:   cmd.load_wr = sts.load_ok;
         ST_ADD_RD: begin
            cmd.mem_rd   = !sts.span_done && !sts.whole_blk;
            cmd.add_step = !sts.span_done && sts.whole_blk;
         end
         ST_ADD_WR: cmd.add_step = 1'b1;
         ST_Q_RD:   cmd.mem_rd = !sts.span_done;
         ST_Q_CMP:  cmd.q_cmp = 1'b1;
         ST_RESP:   cmd.resp_set = !sts.rsp_busy;
         default: ;
      endcase
   end

endmodule

// ----- design/ravss_dp.sv -----
module ravss_dp
   import ravss_pkg::*;
#(
   parameter int MaxElems = MaxElemsDefault,
   parameter int BlockLen = BlockLenDefault
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ModeWidth-1:0]         req_mode,
   input  logic [PosWidth-1:0]          req_first,
   input  logic [PosWidth-1:0]          req_last,
   input  logic [AmountWidth-1:0]       req_amount,
   input  logic [ValueWidth-1:0]        req_value,
   input  logic                         csr_we,
   input  logic [PosWidth-1:0]          csr_data,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_found,
   output logic [DistWidth-1:0]         rsp_distance
);

   localparam int NumBlocks = (MaxElems + BlockLen - 1) / BlockLen;
   localparam int IdxW      = (MaxElems > 1) ? $clog2(MaxElems) : 1;
   localparam int BlkW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
   localparam int CurW      = IdxW + 1;
   localparam int OffW      = (BlockLen > 1) ? $clog2(BlockLen) : 1;
   localparam int WideW     = CurW + 8;

   logic [WordWidth-1:0] mem [MaxElems];
   logic [WordWidth-1:0] rdata_ff;
   logic [WordWidth-1:0] boff_mem [NumBlocks];
   logic [NumBlocks-1:0] boff_vld_ff;
   logic [WordWidth-1:0] boff_rd_ff;   // offset of the block under the cursor

   logic [PosWidth-1:0]  count_ff;
   mode_type             mode_ff;
   logic [CurW-1:0]      cur_ff;   // 0-based index
   logic [CurW-1:0]      cur_in;
   logic [CurW-1:0]      end_ff;   // exclusive end
   logic [AmountWidth-1:0] amt_ff;
   logic [ValueWidth-1:0]  val_ff;
   logic                 hit_ff;
   logic [CurW-1:0]      lo_ff, hi_ff;
   logic                 rsp_valid_ff, rsp_found_ff;
   logic [DistWidth-1:0] rsp_dist_ff;
   logic                 load_ok_ff;

   logic [CurW-1:0]      cnt_use;
   logic [WideW-1:0]     first_w, last_w, cnt_w, lim_w;
   logic [IdxW-1:0]      cur_idx;
   logic [BlkW-1:0]      cur_blk;
   logic [BlkW-1:0]      rd_blk;
   logic [CurW-1:0]      cur_off;
   logic [WideW-1:0]     blk_end_w;
   logic [WordWidth-1:0] eff;

   assign cnt_w   = (WideW'(count_ff) > WideW'(MaxElems)) ? WideW'(MaxElems)
                                                          : WideW'(count_ff);
   assign cnt_use = cnt_w[CurW-1:0];
   assign first_w = (req_first == '0) ? WideW'(1) : WideW'(req_first);
   assign last_w  = (WideW'(req_last) > cnt_w) ? cnt_w : WideW'(req_last);
   assign lim_w   = (req_first == '0) ? WideW'(1) : WideW'(req_first);

   assign cur_idx = cur_ff[IdxW-1:0];
   assign cur_blk = BlkW'(cur_ff / CurW'(BlockLen));
   assign cur_off = cur_ff % CurW'(BlockLen);
   assign blk_end_w = WideW'(cur_ff) + WideW'(BlockLen);
   assign eff     = rdata_ff + boff_rd_ff;

   assign sts.mode      = mode_type'(cmd.capture ? req_mode : mode_ff);
   assign sts.span_done = (cur_ff >= end_ff);
   assign sts.whole_blk = (cur_off == '0) && (blk_end_w <= WideW'(end_ff))
                          && (mode_ff == MODE_ADD);
   assign sts.rsp_busy  = rsp_valid_ff;
   assign sts.load_ok   = load_ok_ff;

   // next cursor; block offset at this address is registered alongside the cursor
   always_comb begin
      cur_in = cur_ff;
      if (cmd.capture) begin
         if (mode_type'(req_mode) == MODE_QUERY) begin
            cur_in = '0;
         end else if (mode_type'(req_mode) == MODE_LOAD) begin
            cur_in = CurW'(lim_w - WideW'(1));
         end else begin
            cur_in = CurW'(first_w - WideW'(1));
         end
      end else if (cmd.add_step) begin
         if (sts.whole_blk) begin
            cur_in = CurW'(blk_end_w);
         end else begin
            cur_in = cur_ff + CurW'(1);
         end
      end else if (cmd.q_cmp) begin
         cur_in = cur_ff + CurW'(1);
      end
   end

   assign rd_blk = BlkW'(cur_in / CurW'(BlockLen));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CountReset;
         rsp_valid_ff <= 1'b0;
         boff_vld_ff  <= '0;
      end else begin
         if (csr_we) count_ff <= csr_data;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cmd.resp_set) rsp_valid_ff <= 1'b1;
         if (cmd.add_step && sts.whole_blk) boff_vld_ff[cur_blk] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      boff_rd_ff <= boff_vld_ff[rd_blk] ? boff_mem[rd_blk] : '0;
      if (cmd.add_step && sts.whole_blk)
         boff_mem[cur_blk] <= boff_rd_ff + WordWidth'(amt_ff);
      if (cmd.capture) begin
         mode_ff    <= mode_type'(req_mode);
         amt_ff     <= req_amount;
         val_ff     <= req_value;
         hit_ff     <= 1'b0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         load_ok_ff <= (req_first != '0) && (WideW'(req_first) <= WideW'(MaxElems));
         if (mode_type'(req_mode) == MODE_QUERY) begin
            end_ff <= cnt_use;
         end else if (mode_type'(req_mode) == MODE_LOAD) begin
            end_ff <= '0;
         end else begin
            end_ff <= (first_w > last_w) ? CurW'(first_w - WideW'(1))
                                         : CurW'(last_w);
         end
      end
      if (cmd.load_wr)
         mem[cur_idx] <= {1'b0, val_ff} - boff_rd_ff;
      if (cmd.mem_rd)
         rdata_ff <= mem[cur_idx];
      if (cmd.add_step && !sts.whole_blk)
         mem[cur_idx] <= rdata_ff + WordWidth'(amt_ff);
      if (cmd.q_cmp) begin
         if (eff == {1'b0, val_ff}) begin
            if (!hit_ff) lo_ff <= cur_ff;
            hi_ff  <= cur_ff;
            hit_ff <= 1'b1;
         end
      end
      if (cmd.resp_set) begin
         rsp_found_ff <= hit_ff;
         rsp_dist_ff  <= hit_ff ? DistWidth'(hi_ff - lo_ff) : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_distance = rsp_dist_ff;

endmodule

// ----- design/range_add_value_span_search_unit.sv -----
// Load: one write of the element. Range add: a read and a write per partially
// covered element, one offset update per whole block. Query: a read and a compare
// per element in use, then a response. One item at a time.
// Reset: synchronous active high; clears block offsets, element count to 4096,
// result valid; element memory is not cleared.
module range_add_value_span_search_unit
   import ravss_pkg::*;
#(
   parameter int MaxElems = MaxElemsDefault,
   parameter int BlockLen = BlockLenDefault
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // mode[1:0], first_pos[14:2], last_pos[27:15],
                                     // amount[59:28], value[122:60]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // found[0], distance[12:1]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data     // element_count[12:0]
);

   cmd_type cmd;
   sts_type sts;
   logic    found;
   logic [DistWidth-1:0] rsp_dist;

   assign csr_ready = 1'b1;

   ravss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ravss_dp #(.MaxElems(MaxElems), .BlockLen(BlockLen)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_tdata[1:0]),
      .req_first    (req_tdata[14:2]),
      .req_last     (req_tdata[27:15]),
      .req_amount   (req_tdata[59:28]),
      .req_value    (req_tdata[122:60]),
      .csr_we       (csr_valid),
      .csr_data     (csr_data[12:0]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_found    (found),
      .rsp_distance (rsp_dist)
   );

   assign rsp_tdata = {3'b000, rsp_dist, found};

`ifndef NO_ASSERTIONS
   a_no_found_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[12:1] == '0)
      else $error("distance nonzero without match");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_rd || cmd.q_cmp || cmd.add_step) |-> !req_tready)
      else $error("accepting during scan");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.load_wr, cmd.mem_rd, cmd.q_cmp, cmd.resp_set}))
      else $error("conflicting commands");
`endif

endmodule
